>>> rtl/core/avcf_pkg.sv
// Shared types and constants for the alert voice command framer.
package avcf_pkg;

   // Request kinds
   localparam logic REQ_ALERT  = 1'b0;
   localparam logic REQ_DIRECT = 1'b1;

   // Gas channel codes
   localparam logic [1:0] GAS_NONE = 2'd0;
   localparam logic [1:0] GAS_CO   = 2'd1;
   localparam logic [1:0] GAS_LPG  = 2'd2;
   localparam logic [1:0] GAS_CO2  = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_CO       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_LPG      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_CO2      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_CLEAR    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLAY_COOLDOWN = 3'd4;

   // Register reset values
   localparam logic [15:0] TRACK_CO_RESET    = 16'd3;
   localparam logic [15:0] TRACK_LPG_RESET   = 16'd4;
   localparam logic [15:0] TRACK_CO2_RESET   = 16'd5;
   localparam logic [15:0] TRACK_CLEAR_RESET = 16'd6;
   localparam logic [31:0] COOLDOWN_RESET    = 32'd15000;

   // Command codes and limits
   localparam logic [7:0]  CMD_VOLUME = 8'h06;
   localparam logic [7:0]  CMD_PLAY   = 8'h12;
   localparam logic [15:0] VOLUME_MAX = 16'd30;

   // Fixed frame bytes
   localparam logic [7:0] FRAME_START   = 8'h7E;
   localparam logic [7:0] FRAME_VERSION = 8'hFF;
   localparam logic [7:0] FRAME_LENGTH  = 8'h06;
   localparam logic [7:0] FRAME_NO_ACK  = 8'h00;
   localparam logic [7:0] FRAME_END     = 8'hEF;

   // Byte position within a frame, in transmit order
   typedef enum logic [3:0] {
      POS_START   = 4'd0,
      POS_VERSION = 4'd1,
      POS_LENGTH  = 4'd2,
      POS_COMMAND = 4'd3,
      POS_ACK     = 4'd4,
      POS_PARAM_H = 4'd5,
      POS_PARAM_L = 4'd6,
      POS_CHK_H   = 4'd7,
      POS_CHK_L   = 4'd8,
      POS_END     = 4'd9
   } frame_pos_type;

   // One frame to be sent, as passed from front to back
   typedef struct packed {
      logic [7:0]  command;
      logic [15:0] param;
   } frame_req_type;

endpackage

>>> rtl/core/avcf_front.sv
// Front end: configuration registers, alert decision and frame requests.
module avcf_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [avcf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [avcf_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                  accept,
   input  logic                                  req_type,
   input  logic                                  req_is_critical,
   input  logic [1:0]                            req_gas_channel,
   input  logic [31:0]                           req_now_ms,
   input  logic [7:0]                            req_command_code,
   input  logic [15:0]                           req_param_value,
   output logic                                  frame_push,
   output avcf_pkg::frame_req_type               frame_req
);

   logic [15:0] track_co_ff,    track_co_in;
   logic [15:0] track_lpg_ff,   track_lpg_in;
   logic [15:0] track_co2_ff,   track_co2_in;
   logic [15:0] track_clear_ff, track_clear_in;
   logic [31:0] cooldown_ff,    cooldown_in;

   logic [31:0] last_play_ff,  last_play_in;
   logic [1:0]  announced_ff,  announced_in;
   logic        alert_ff,      alert_in;

   logic [15:0] track;
   logic        desired_valid;
   logic [31:0] elapsed;

   // Register writes; unknown indexes drop silently
   always_comb begin
      track_co_in    = track_co_ff;
      track_lpg_in   = track_lpg_ff;
      track_co2_in   = track_co2_ff;
      track_clear_in = track_clear_ff;
      cooldown_in    = cooldown_ff;
      if (csr_write_enable) begin
         case (csr_index)
            avcf_pkg::CSR_TRACK_CO:        track_co_in    = csr_write_data[15:0];
            avcf_pkg::CSR_TRACK_LPG:       track_lpg_in   = csr_write_data[15:0];
            avcf_pkg::CSR_TRACK_CO2:       track_co2_in   = csr_write_data[15:0];
            avcf_pkg::CSR_TRACK_CLEAR:     track_clear_in = csr_write_data[15:0];
            avcf_pkg::CSR_REPLAY_COOLDOWN: cooldown_in    = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (req_gas_channel)
         avcf_pkg::GAS_CO:  track = track_co_ff;
         avcf_pkg::GAS_LPG: track = track_lpg_ff;
         avcf_pkg::GAS_CO2: track = track_co2_ff;
         default:           track = 16'd0;
      endcase
   end

   assign desired_valid = req_is_critical && (track != 16'd0);
   assign elapsed       = req_now_ms - last_play_ff;

   // Decide whether this transaction produces a frame and update alert state
   always_comb begin
      last_play_in      = last_play_ff;
      announced_in      = announced_ff;
      alert_in          = alert_ff;
      frame_push        = 1'b0;
      frame_req.command = avcf_pkg::CMD_PLAY;
      frame_req.param   = track;
      if (accept) begin
         if (req_type == avcf_pkg::REQ_DIRECT) begin
            frame_push        = 1'b1;
            frame_req.command = req_command_code;
            if (req_command_code == avcf_pkg::CMD_VOLUME &&
                req_param_value > avcf_pkg::VOLUME_MAX) begin
               frame_req.param = avcf_pkg::VOLUME_MAX;
            end else begin
               frame_req.param = req_param_value;
            end
         end else if (!desired_valid) begin
            if (alert_ff) begin
               frame_push      = 1'b1;
               frame_req.param = track_clear_ff;
               alert_in        = 1'b0;
               announced_in    = avcf_pkg::GAS_NONE;
               last_play_in    = req_now_ms;
            end
         end else if (req_gas_channel != announced_ff) begin
            frame_push   = 1'b1;
            announced_in = req_gas_channel;
            alert_in     = 1'b1;
            last_play_in = req_now_ms;
         end else if (elapsed >= cooldown_ff) begin
            frame_push   = 1'b1;
            last_play_in = req_now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_co_ff    <= avcf_pkg::TRACK_CO_RESET;
         track_lpg_ff   <= avcf_pkg::TRACK_LPG_RESET;
         track_co2_ff   <= avcf_pkg::TRACK_CO2_RESET;
         track_clear_ff <= avcf_pkg::TRACK_CLEAR_RESET;
         cooldown_ff    <= avcf_pkg::COOLDOWN_RESET;
         last_play_ff   <= 32'd0;
         announced_ff   <= avcf_pkg::GAS_NONE;
         alert_ff       <= 1'b0;
      end else begin
         track_co_ff    <= track_co_in;
         track_lpg_ff   <= track_lpg_in;
         track_co2_ff   <= track_co2_in;
         track_clear_ff <= track_clear_in;
         cooldown_ff    <= cooldown_in;
         last_play_ff   <= last_play_in;
         announced_ff   <= announced_in;
         alert_ff       <= alert_in;
      end
   end

endmodule

>>> rtl/core/avcf_queue.sv
// Short queue of frame requests between front and back.
module avcf_queue #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  avcf_pkg::frame_req_type push_data,
   input  logic                    pop,
   output logic                    full,
   output logic                    empty,
   output avcf_pkg::frame_req_type head
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   avcf_pkg::frame_req_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/avcf_back.sv
// Back end: frame serializer, one byte per result transaction.
module avcf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  avcf_pkg::frame_req_type q_head,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_end_of_frame
);

   logic                    busy_ff,    busy_in;
   avcf_pkg::frame_pos_type pos_ff,     pos_in;
   logic [7:0]              command_ff, command_in;
   logic [15:0]             param_ff,   param_in;
   logic [15:0]             chk_ff,     chk_in;
   logic                    last_taken;
   logic [15:0]             sum;

   assign last_taken = busy_ff && rsp_pop && (pos_ff == avcf_pkg::POS_END);
   assign q_pop      = !q_empty && (!busy_ff || last_taken);

   // Sum of bytes one to six; the no-ack byte adds nothing
   assign sum = 16'(avcf_pkg::FRAME_VERSION) + 16'(avcf_pkg::FRAME_LENGTH)
              + 16'(q_head.command) + 16'(avcf_pkg::FRAME_NO_ACK)
              + 16'(q_head.param[15:8]) + 16'(q_head.param[7:0]);

   always_comb begin
      busy_in    = busy_ff;
      pos_in     = pos_ff;
      command_in = command_ff;
      param_in   = param_ff;
      chk_in     = chk_ff;
      if (q_pop) begin
         busy_in    = 1'b1;
         pos_in     = avcf_pkg::POS_START;
         command_in = q_head.command;
         param_in   = q_head.param;
         chk_in     = 16'd0 - sum;
      end else if (last_taken) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_pop) begin
         pos_in = avcf_pkg::frame_pos_type'(pos_ff + 4'd1);
      end
   end

   always_comb begin
      case (pos_ff)
         avcf_pkg::POS_START:   rsp_frame_byte = avcf_pkg::FRAME_START;
         avcf_pkg::POS_VERSION: rsp_frame_byte = avcf_pkg::FRAME_VERSION;
         avcf_pkg::POS_LENGTH:  rsp_frame_byte = avcf_pkg::FRAME_LENGTH;
         avcf_pkg::POS_COMMAND: rsp_frame_byte = command_ff;
         avcf_pkg::POS_ACK:     rsp_frame_byte = avcf_pkg::FRAME_NO_ACK;
         avcf_pkg::POS_PARAM_H: rsp_frame_byte = param_ff[15:8];
         avcf_pkg::POS_PARAM_L: rsp_frame_byte = param_ff[7:0];
         avcf_pkg::POS_CHK_H:   rsp_frame_byte = chk_ff[15:8];
         avcf_pkg::POS_CHK_L:   rsp_frame_byte = chk_ff[7:0];
         avcf_pkg::POS_END:     rsp_frame_byte = avcf_pkg::FRAME_END;
         default:               rsp_frame_byte = avcf_pkg::FRAME_END;
      endcase
   end

   assign rsp_end_of_frame = (pos_ff == avcf_pkg::POS_END);
   assign rsp_empty        = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= avcf_pkg::POS_START;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      command_ff <= command_in;
      param_ff   <= param_in;
      chk_ff     <= chk_in;
   end

endmodule

>>> rtl/core/alert_voice_command_framer.sv
// Top level of the alert voice command framer.
//
//   channel   direction  handshake           transaction carries
//   req_*     in         push / full         one alert update or direct command
//   rsp_*     out        pop / empty         one frame byte with end-of-frame flag
//   csr_*     in         write_enable only   one register write, no wait
//
// A frame is ten result transactions, one byte a cycle while pop is held; the
// serializer in the back end limits a sustained stream of frame-producing
// requests. Requests that produce no frame are taken one a cycle while the
// request queue is not full. A request is classified in the cycle it is
// accepted, and its frame is registered in the request queue before the
// serializer loads it. Reset is synchronous; there is no clearing pass. full
// rises only when the request queue holds QUEUE_DEPTH frames while the back
// end is still sending, so output stalls back up into the input.
module alert_voice_command_framer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             push,
   output logic                             full,
   input  logic                             req_type,
   input  logic                             req_is_critical,
   input  logic [1:0]                       req_gas_channel,
   input  logic [31:0]                      req_now_ms,
   input  logic [7:0]                       req_command_code,
   input  logic [15:0]                      req_param_value,
   // result channel
   output logic                             empty,
   input  logic                             pop,
   output logic [7:0]                       rsp_frame_byte,
   output logic                             rsp_end_of_frame,
   // configuration
   input  logic                             csr_write_enable,
   input  logic [avcf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [avcf_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic                    accept;
   logic                    frame_push;
   avcf_pkg::frame_req_type frame_req;
   logic                    q_full;
   logic                    q_empty;
   logic                    q_pop;
   avcf_pkg::frame_req_type q_head;

   // Hold off requests only while the queue cannot take a frame
   assign full   = q_full;
   assign accept = push && !q_full;

   // Classify each transaction and keep the alert state
   avcf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_type         (req_type),
      .req_is_critical  (req_is_critical),
      .req_gas_channel  (req_gas_channel),
      .req_now_ms       (req_now_ms),
      .req_command_code (req_command_code),
      .req_param_value  (req_param_value),
      .frame_push       (frame_push),
      .frame_req        (frame_req)
   );

   // Decouple the decision from the slow byte stream
   avcf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame_req),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Serialize frames; the next frame loads as the last byte is taken
   avcf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule
